/* hw/rtl/swtm_pkg.sv */
`default_nettype none

package swtm_pkg;

	// Fixed field widths of the section and report transactions.
	localparam int PHASE_BITS     = 3;
	localparam int EXTENT_BITS    = 24;
	localparam int ARC_BITS       = 32;
	localparam int STATUS_BITS    = 2;
	localparam int REASON_BITS    = 3;
	localparam int COUNT_OUT_BITS = 16;

	// Configuration port.
	localparam int REG_BITS  = 16;
	localparam int ADDR_BITS = 4;
	localparam int DATA_BITS = 32;

	// Defaults for the top-level parameters.
	localparam int VALUE_BITS_DEF = 24;
	localparam int COUNT_BITS_DEF = 16;

	// Tolerance is 32 * epsilon + 2 * arc tolerance, which fits in 22 bits.
	localparam int TOL_BITS      = 22;
	localparam int TOL_EPS_SHIFT = 5;
	localparam int TOL_ARC_SHIFT = 1;

	localparam logic [REG_BITS-1:0] GEOMETRY_EPSILON_RESET = 16'd1;
	localparam logic [REG_BITS-1:0] ARC_TOLERANCE_RESET    = 16'd64;
	localparam logic [REG_BITS-1:0] MAX_SECTIONS_RESET     = 16'd256;

	// Phase codes carried by a section.
	localparam logic [PHASE_BITS-1:0] PH_WIDENING = 3'd1;
	localparam logic [PHASE_BITS-1:0] PH_JOIN     = 3'd2;
	localparam logic [PHASE_BITS-1:0] PH_TERMINAL = 3'd3;
	localparam logic [PHASE_BITS-1:0] PH_CONTACT  = 3'd4;

	typedef enum logic [STATUS_BITS-1:0] {
		ST_CLEAR       = 2'd0,
		ST_VIOLATION   = 2'd1,
		ST_UNSUPPORTED = 2'd2
	} status_t;

	typedef enum logic [REASON_BITS-1:0] {
		RS_NONE         = 3'd0,
		RS_WIDTH_VALLEY = 3'd1,
		RS_INWARD_SIDE  = 3'd2,
		RS_TERMINAL_EXP = 3'd3,
		RS_INVALID      = 3'd4,
		RS_WORK_LIMIT   = 3'd5
	} reason_t;

	typedef enum logic [1:0] {
		REG_GEOMETRY_EPSILON = 2'd0,
		REG_ARC_TOLERANCE    = 2'd1,
		REG_MAX_SECTIONS     = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [TOL_BITS-1:0] tol;
		logic [REG_BITS-1:0] max_sections;
	} cfg_t;

	typedef struct packed {
		logic en;
		logic clr;
	} trk_ctl_t;

	function automatic logic [TOL_BITS-1:0] tol_of(input logic [REG_BITS-1:0] eps,
			input logic [REG_BITS-1:0] arc);
		logic [TOL_BITS-1:0] a;
		logic [TOL_BITS-1:0] b;
		a = TOL_BITS'(eps) << TOL_EPS_SHIFT;
		b = TOL_BITS'(arc) << TOL_ARC_SHIFT;
		return a + b;
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/swtm_if.sv */
`default_nettype none

interface swtm_section_if;
	import swtm_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [PHASE_BITS-1:0]  phase;
	logic [EXTENT_BITS-1:0] left_extent;
	logic [EXTENT_BITS-1:0] right_extent;
	logic [ARC_BITS-1:0]    arclength;
	logic                   last_section;

	modport source (output valid, phase, left_extent, right_extent, arclength, last_section,
		input ready);
	modport sink (input valid, phase, left_extent, right_extent, arclength, last_section,
		output ready);
endinterface

interface swtm_report_if;
	import swtm_pkg::*;

	logic                      valid;
	logic                      ready;
	logic [STATUS_BITS-1:0]    status;
	logic [REASON_BITS-1:0]    reason;
	logic [EXTENT_BITS-1:0]    minimum_width;
	logic [EXTENT_BITS-1:0]    maximum_width;
	logic [EXTENT_BITS-1:0]    max_left_inward;
	logic [EXTENT_BITS-1:0]    max_right_inward;
	logic [EXTENT_BITS-1:0]    max_width_drawdown;
	logic [EXTENT_BITS-1:0]    width_valley_depth;
	logic [COUNT_OUT_BITS-1:0] sections_evaluated;

	modport source (output valid, status, reason, minimum_width, maximum_width,
		max_left_inward, max_right_inward, max_width_drawdown, width_valley_depth,
		sections_evaluated, input ready);
	modport sink (input valid, status, reason, minimum_width, maximum_width,
		max_left_inward, max_right_inward, max_width_drawdown, width_valley_depth,
		sections_evaluated, output ready);
endinterface

`default_nettype wire

/* hw/rtl/swtm_cfg_regs.sv */
`default_nettype none

module swtm_cfg_regs (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [swtm_pkg::ADDR_BITS-1:0] paddr,
	input  wire logic [swtm_pkg::DATA_BITS-1:0] pwdata,
	output logic      [swtm_pkg::DATA_BITS-1:0] prdata,
	output logic                               pready,
	output swtm_pkg::cfg_t                     cfg
);
	import swtm_pkg::*;

	logic [REG_BITS-1:0] eps_q;
	logic [REG_BITS-1:0] arc_q;
	logic [REG_BITS-1:0] max_q;
	logic                wr;
	reg_idx_t            idx;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;
	assign idx    = reg_idx_t'(paddr[ADDR_BITS-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= GEOMETRY_EPSILON_RESET;
			arc_q <= ARC_TOLERANCE_RESET;
			max_q <= MAX_SECTIONS_RESET;
		end else begin
			if (wr) begin
				case (idx)
					REG_GEOMETRY_EPSILON: eps_q <= pwdata[REG_BITS-1:0];
					REG_ARC_TOLERANCE:    arc_q <= pwdata[REG_BITS-1:0];
					REG_MAX_SECTIONS:     max_q <= pwdata[REG_BITS-1:0];
					default: ;
				endcase
			end
		end
	end

	always_comb begin
		case (idx)
			REG_GEOMETRY_EPSILON: prdata = DATA_BITS'(eps_q);
			REG_ARC_TOLERANCE:    prdata = DATA_BITS'(arc_q);
			REG_MAX_SECTIONS:     prdata = DATA_BITS'(max_q);
			default:              prdata = '0;
		endcase
	end

	// The tolerance is only two shifts and an add, so it follows the registers directly.
	assign cfg.tol          = tol_of(eps_q, arc_q);
	assign cfg.max_sections = max_q;

endmodule

`default_nettype wire

/* hw/rtl/swtm_tracker.sv */
`default_nettype none

module swtm_tracker #(
	parameter int VALUE_BITS = swtm_pkg::VALUE_BITS_DEF,
	parameter bit HAS_VALLEY = 1'b0
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire swtm_pkg::trk_ctl_t    ctl,
	input  wire logic [VALUE_BITS-1:0] value,
	output logic      [VALUE_BITS-1:0] drawdown_nx,
	output logic      [VALUE_BITS-1:0] valley_nx,
	output logic                       seen
);
	import swtm_pkg::*;

	logic [VALUE_BITS-1:0] peak_q;
	logic [VALUE_BITS-1:0] trough_q;
	logic [VALUE_BITS-1:0] dd_q;
	logic                  seen_q;
	logic [VALUE_BITS-1:0] trough_lo;
	logic [VALUE_BITS-1:0] fall;
	logic [VALUE_BITS-1:0] dd_calc;
	logic [VALUE_BITS-1:0] peak_nx;
	logic [VALUE_BITS-1:0] trough_nx;

	always_comb begin
		trough_lo = (value < trough_q) ? value : trough_q;
		fall      = peak_q - value;
		dd_calc   = dd_q;
		if (peak_q > value && fall > dd_q) begin
			dd_calc = fall;
		end
		// The first sample, or a new peak, restarts both peak and trough.
		if (!seen_q || value >= peak_q) begin
			peak_nx   = value;
			trough_nx = value;
		end else begin
			peak_nx   = peak_q;
			trough_nx = trough_lo;
		end
		drawdown_nx = (ctl.en && seen_q) ? dd_calc : dd_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_q   <= '0;
			trough_q <= '0;
			dd_q     <= '0;
			seen_q   <= 1'b0;
		end else if (ctl.clr) begin
			peak_q   <= '0;
			trough_q <= '0;
			dd_q     <= '0;
			seen_q   <= 1'b0;
		end else if (ctl.en) begin
			peak_q   <= peak_nx;
			trough_q <= trough_nx;
			dd_q     <= drawdown_nx;
			seen_q   <= 1'b1;
		end
	end

	assign seen = seen_q;

	generate
		if (HAS_VALLEY) begin : g_valley
			logic [VALUE_BITS-1:0] valley_q;
			logic [VALUE_BITS-1:0] v_fall;
			logic [VALUE_BITS-1:0] v_rise;
			logic [VALUE_BITS-1:0] v_min;

			// Valley depth is the smaller of the descent from the peak and the
			// climb back out of the trough.
			always_comb begin
				v_fall    = peak_q - trough_lo;
				v_rise    = value - trough_lo;
				v_min     = (v_rise < v_fall) ? v_rise : v_fall;
				valley_nx = (ctl.en && seen_q && v_min > valley_q) ? v_min : valley_q;
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					valley_q <= '0;
				end else if (ctl.clr) begin
					valley_q <= '0;
				end else if (ctl.en) begin
					valley_q <= valley_nx;
				end
			end
		end else begin : g_no_valley
			assign valley_nx = '0;
		end
	endgenerate

endmodule

`default_nettype wire

/* hw/rtl/stroke_width_trend_monitor_unit.sv */
`default_nettype none

// Channel  | Direction | Protocol        | Content
// section  | in        | valid/ready     | one measured cross-section per transaction
// report   | out       | valid/ready     | status, reason and statistics of a finished run
// APB      | in/out    | setup + access  | epsilon, arc tolerance, section limit
//
// Each section is taken into an input register and, on leaving it, folded into the
// running state and, if it closes the run, into the report register. One section per
// cycle is sustained outside stalls; the state update is a loop through registers.
// A non-last section moves on even while a report waits, so input only stalls when a
// last section meets a report register that is still full.
// Asynchronous active-low reset clears all run state and the handshake registers;
// configuration registers return to their documented reset values.

module stroke_width_trend_monitor_unit #(
	parameter int VALUE_BITS = swtm_pkg::VALUE_BITS_DEF,
	parameter int COUNT_BITS = swtm_pkg::COUNT_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	swtm_section_if.sink                       section,
	swtm_report_if.source                      report,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [swtm_pkg::ADDR_BITS-1:0] paddr,
	input  wire logic [swtm_pkg::DATA_BITS-1:0] pwdata,
	output logic      [swtm_pkg::DATA_BITS-1:0] prdata,
	output logic                               pready
);
	import swtm_pkg::*;

	// Working widths: the wide domain holds an extent before it is clamped to
	// VALUE_BITS, the compare domain holds a value plus the tolerance.
	localparam int CNT_W = COUNT_BITS + 1;
	localparam int WB    = ((VALUE_BITS > EXTENT_BITS) ? VALUE_BITS : EXTENT_BITS) + 1;
	localparam int OW    = (VALUE_BITS > EXTENT_BITS) ? VALUE_BITS : EXTENT_BITS;
	localparam int CW    = ((VALUE_BITS > TOL_BITS) ? VALUE_BITS : TOL_BITS) + 1;
	localparam int MW    = (CNT_W > REG_BITS) ? CNT_W : REG_BITS;
	localparam logic [WB-1:0] VMAX_W = WB'({VALUE_BITS{1'b1}});

	function automatic logic [EXTENT_BITS-1:0] to_field(input logic [VALUE_BITS-1:0] v);
		logic [OW-1:0] w;
		w = OW'(v);
		return w[EXTENT_BITS-1:0];
	endfunction

	cfg_t cfg;

	swtm_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// ---------------------------------------------------------------- input stage
	logic                   s1_valid_q;
	logic [PHASE_BITS-1:0]  phase_s1;
	logic [EXTENT_BITS-1:0] left_s1;
	logic [EXTENT_BITS-1:0] right_s1;
	logic [ARC_BITS-1:0]    arc_s1;
	logic                   last_s1;
	logic                   s1_adv;
	logic                   in_take;
	logic                   rpt_valid_q;

	// A section leaves the input stage unless it closes a run and the report
	// register is still holding an untaken transaction.
	assign s1_adv        = s1_valid_q && (!last_s1 || !rpt_valid_q || report.ready);
	assign section.ready = !s1_valid_q || s1_adv;
	assign in_take       = section.valid && section.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_take) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			phase_s1 <= section.phase;
			left_s1  <= section.left_extent;
			right_s1 <= section.right_extent;
			arc_s1   <= section.arclength;
			last_s1  <= section.last_section;
		end
	end

	// ---------------------------------------------------------------- run state
	logic [CNT_W-1:0]      cnt_q;
	logic [ARC_BITS-1:0]   prior_arc_q;
	logic [PHASE_BITS-1:0] prior_phase_q;
	logic [VALUE_BITS-1:0] low_q;
	logic [VALUE_BITS-1:0] high_q;
	logic [VALUE_BITS-1:0] floor_q;
	logic                  begun_q;
	logic                  grew_q;
	logic [1:0]            err_q;

	// Extents are clamped to the value range, and so is their sum.
	logic [WB-1:0]         left_w;
	logic [WB-1:0]         right_w;
	logic [VALUE_BITS-1:0] left_v;
	logic [VALUE_BITS-1:0] right_v;
	logic [VALUE_BITS:0]   wsum;
	logic [VALUE_BITS-1:0] width_v;

	always_comb begin
		left_w  = WB'(left_s1);
		right_w = WB'(right_s1);
		left_v  = (left_w > VMAX_W) ? {VALUE_BITS{1'b1}} : left_w[VALUE_BITS-1:0];
		right_v = (right_w > VMAX_W) ? {VALUE_BITS{1'b1}} : right_w[VALUE_BITS-1:0];
		wsum    = {1'b0, left_v} + {1'b0, right_v};
		width_v = wsum[VALUE_BITS] ? {VALUE_BITS{1'b1}} : wsum[VALUE_BITS-1:0];
	end

	// Ordering and count checks. Bit 0 of the error flags marks an invalid
	// section, bit 1 a run that went past the section limit.
	logic             first;
	logic             bad;
	logic [CNT_W-1:0] cnt_nx;
	logic             over;
	logic [1:0]       err_nx;
	logic             live;
	logic             is_trend;
	logic             is_term;

	always_comb begin
		first  = (cnt_q == '0);
		bad    = (phase_s1 > PH_CONTACT) || (phase_s1 == PH_CONTACT && !last_s1) ||
			(!first && (arc_s1 <= prior_arc_q || phase_s1 < prior_phase_q));
		cnt_nx = cnt_q + CNT_W'(!(&cnt_q));
		over   = MW'(cnt_nx) > MW'(cfg.max_sections);
		err_nx = err_q | {over, bad};
		// Once any error is flagged the statistics stop moving for the rest of the run.
		live     = (err_nx == 2'b00);
		is_trend = (phase_s1 == PH_WIDENING) || (phase_s1 == PH_JOIN);
		is_term  = (phase_s1 == PH_TERMINAL) || (phase_s1 == PH_CONTACT);
	end

	// Trend trackers on left, right and width over widening and join.
	trk_ctl_t              trk_ctl;
	logic [VALUE_BITS-1:0] dd_left;
	logic [VALUE_BITS-1:0] dd_right;
	logic [VALUE_BITS-1:0] dd_width;
	logic [VALUE_BITS-1:0] valley_nx;
	logic [VALUE_BITS-1:0] valley_left;
	logic [VALUE_BITS-1:0] valley_right;
	logic                  seen_left;
	logic                  seen_right;
	logic                  seen_width;

	assign trk_ctl.en  = s1_adv && live && is_trend;
	assign trk_ctl.clr = s1_adv && last_s1;

	swtm_tracker #(.VALUE_BITS(VALUE_BITS), .HAS_VALLEY(1'b0)) u_trk_left (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (trk_ctl),
		.value       (left_v),
		.drawdown_nx (dd_left),
		.valley_nx   (valley_left),
		.seen        (seen_left)
	);

	swtm_tracker #(.VALUE_BITS(VALUE_BITS), .HAS_VALLEY(1'b0)) u_trk_right (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (trk_ctl),
		.value       (right_v),
		.drawdown_nx (dd_right),
		.valley_nx   (valley_right),
		.seen        (seen_right)
	);

	swtm_tracker #(.VALUE_BITS(VALUE_BITS), .HAS_VALLEY(1'b1)) u_trk_width (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (trk_ctl),
		.value       (width_v),
		.drawdown_nx (dd_width),
		.valley_nx   (valley_nx),
		.seen        (seen_width)
	);

	// Width envelope and terminal re-expansion watch.
	logic [VALUE_BITS-1:0] low_nx;
	logic [VALUE_BITS-1:0] high_nx;
	logic [VALUE_BITS-1:0] floor_nx;
	logic [VALUE_BITS-1:0] floor_base;
	logic                  begun_nx;
	logic                  grew_nx;

	always_comb begin
		low_nx     = low_q;
		high_nx    = high_q;
		floor_nx   = floor_q;
		begun_nx   = begun_q;
		grew_nx    = grew_q;
		floor_base = floor_q;
		if (live) begin
			if (first) begin
				low_nx  = width_v;
				high_nx = width_v;
			end else begin
				if (width_v < low_q) begin
					low_nx = width_v;
				end
				if (width_v > high_q) begin
					high_nx = width_v;
				end
			end
			if (is_trend) begin
				floor_nx = width_v;
			end else if (is_term) begin
				// Entering the terminal phases without any trend history starts the
				// floor at the present width.
				if (!begun_q && !seen_width) begin
					floor_base = width_v;
				end
				begun_nx = 1'b1;
				if (CW'(width_v) > CW'(floor_base) + CW'(cfg.tol)) begin
					grew_nx = 1'b1;
				end
				floor_nx = (width_v < floor_base) ? width_v : floor_base;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q         <= '0;
			prior_arc_q   <= '0;
			prior_phase_q <= '0;
			low_q         <= '0;
			high_q        <= '0;
			floor_q       <= '0;
			begun_q       <= 1'b0;
			grew_q        <= 1'b0;
			err_q         <= 2'b00;
		end else if (s1_adv) begin
			if (last_s1) begin
				cnt_q         <= '0;
				prior_arc_q   <= '0;
				prior_phase_q <= '0;
				low_q         <= '0;
				high_q        <= '0;
				floor_q       <= '0;
				begun_q       <= 1'b0;
				grew_q        <= 1'b0;
				err_q         <= 2'b00;
			end else begin
				cnt_q         <= cnt_nx;
				prior_arc_q   <= arc_s1;
				prior_phase_q <= phase_s1;
				low_q         <= low_nx;
				high_q        <= high_nx;
				floor_q       <= floor_nx;
				begun_q       <= begun_nx;
				grew_q        <= grew_nx;
				err_q         <= err_nx;
			end
		end
	end

	// ---------------------------------------------------------------- report
	// A work-limit error outranks invalid sections; among violations the valley
	// comes first, then inward sides, then terminal growth.
	status_t                   status_c;
	reason_t                   reason_c;
	logic                      unsup;
	status_t                   status_q;
	reason_t                   reason_q;
	logic [EXTENT_BITS-1:0]    min_q;
	logic [EXTENT_BITS-1:0]    max_q;
	logic [EXTENT_BITS-1:0]    left_in_q;
	logic [EXTENT_BITS-1:0]    right_in_q;
	logic [EXTENT_BITS-1:0]    width_dd_q;
	logic [EXTENT_BITS-1:0]    valley_q;
	logic [COUNT_OUT_BITS-1:0] sections_q;
	logic [MW-1:0]             cnt_m;

	always_comb begin
		unsup = 1'b1;
		cnt_m = MW'(cnt_nx);
		if (err_nx[1]) begin
			status_c = ST_UNSUPPORTED;
			reason_c = RS_WORK_LIMIT;
		end else if (err_nx[0]) begin
			status_c = ST_UNSUPPORTED;
			reason_c = RS_INVALID;
		end else begin
			unsup    = 1'b0;
			status_c = ST_VIOLATION;
			if (CW'(valley_nx) > CW'(cfg.tol)) begin
				reason_c = RS_WIDTH_VALLEY;
			end else if (CW'(dd_left) > CW'(cfg.tol) || CW'(dd_right) > CW'(cfg.tol)) begin
				reason_c = RS_INWARD_SIDE;
			end else if (grew_nx) begin
				reason_c = RS_TERMINAL_EXP;
			end else begin
				status_c = ST_CLEAR;
				reason_c = RS_NONE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rpt_valid_q <= 1'b0;
		end else if (s1_adv && last_s1) begin
			rpt_valid_q <= 1'b1;
		end else if (report.ready) begin
			rpt_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && last_s1) begin
			status_q   <= status_c;
			reason_q   <= reason_c;
			min_q      <= unsup ? '0 : to_field(low_nx);
			max_q      <= unsup ? '0 : to_field(high_nx);
			left_in_q  <= unsup ? '0 : to_field(dd_left);
			right_in_q <= unsup ? '0 : to_field(dd_right);
			width_dd_q <= unsup ? '0 : to_field(dd_width);
			valley_q   <= unsup ? '0 : to_field(valley_nx);
			sections_q <= unsup ? '0 : cnt_m[COUNT_OUT_BITS-1:0];
		end
	end

	assign report.valid              = rpt_valid_q;
	assign report.status             = status_q;
	assign report.reason             = reason_q;
	assign report.minimum_width      = min_q;
	assign report.maximum_width      = max_q;
	assign report.max_left_inward    = left_in_q;
	assign report.max_right_inward   = right_in_q;
	assign report.max_width_drawdown = width_dd_q;
	assign report.width_valley_depth = valley_q;
	assign report.sections_evaluated = sections_q;

	// ---------------------------------------------------------------- checks
	// Closing a run leaves the section counter and error flags cleared.
	a_run_clears: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv && last_s1 |=> cnt_q == '0 && err_q == 2'b00)
		else $error("run state not cleared after a closing section");

	// An unsupported report carries no statistics.
	a_unsup_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rpt_valid_q && status_q == ST_UNSUPPORTED |->
		min_q == '0 && max_q == '0 && sections_q == '0 && valley_q == '0)
		else $error("unsupported report with non-zero statistics");

	// The width envelope stays ordered while a clean run is in progress.
	a_envelope: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != '0 && err_q == 2'b00 |-> low_q <= high_q)
		else $error("minimum width above maximum width");

	// A work-limit error stays flagged until the run closes.
	a_limit_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		err_q[1] && !(s1_adv && last_s1) |=> err_q[1])
		else $error("work-limit flag dropped inside a run");

	// An empty input register always takes a new section.
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!s1_valid_q |-> section.ready)
		else $error("input stalled with an empty input register");

	// The three trackers share one control, so they fill together, and only the
	// width tracker keeps a valley.
	a_trk_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		seen_left == seen_width && seen_right == seen_width &&
		valley_left == '0 && valley_right == '0)
		else $error("side trackers out of step with the width tracker");

endmodule

`default_nettype wire

/* dv/swtm_run_checker.sv */
module swtm_run_checker
	import swtm_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	swtm_section_if                   sections,
	swtm_report_if                    reports,
	input  wire logic                 psel,
	input  wire logic                 penable,
	input  wire logic                 pwrite,
	input  wire logic                 pready,
	input  wire logic [ADDR_BITS-1:0] paddr,
	input  wire logic [DATA_BITS-1:0] pwdata,
	output int unsigned               mismatches,
	output int unsigned               reports_due
);

	localparam int unsigned TOL_EPS_WEIGHT = 32;
	localparam int unsigned TOL_ARC_WEIGHT = 2;

	// Tracker slots for left, right and width.
	localparam int TRK_LEFT  = 0;
	localparam int TRK_RIGHT = 1;
	localparam int TRK_WIDTH = 2;

	typedef struct packed {
		logic [PHASE_BITS-1:0]  phase;
		logic [EXTENT_BITS-1:0] left;
		logic [EXTENT_BITS-1:0] right;
		logic [ARC_BITS-1:0]    arc;
		logic                   last;
	} section_t;

	typedef struct packed {
		status_t                   status;
		reason_t                   reason;
		logic [EXTENT_BITS-1:0]    min_width;
		logic [EXTENT_BITS-1:0]    max_width;
		logic [EXTENT_BITS-1:0]    left_inward;
		logic [EXTENT_BITS-1:0]    right_inward;
		logic [EXTENT_BITS-1:0]    width_drawdown;
		logic [EXTENT_BITS-1:0]    valley;
		logic [COUNT_OUT_BITS-1:0] count;
	} report_t;

	logic [REG_BITS-1:0]    geom_eps;
	logic [REG_BITS-1:0]    arc_tol;
	logic [REG_BITS-1:0]    section_limit;

	logic [COUNT_OUT_BITS:0] run_count;
	logic [ARC_BITS-1:0]     prev_arc;
	logic [PHASE_BITS-1:0]   prev_phase;
	logic [EXTENT_BITS-1:0]  width_min;
	logic [EXTENT_BITS-1:0]  width_max;
	logic [EXTENT_BITS-1:0]  peak [3];
	logic [EXTENT_BITS-1:0]  trough [3];
	logic [EXTENT_BITS-1:0]  drop [3];
	bit                      seen [3];
	logic [EXTENT_BITS-1:0]  valley_max;
	logic [EXTENT_BITS-1:0]  term_floor;
	bit                      term_begun;
	bit                      term_grew;
	bit                      bad_order;
	bit                      over_limit;

	report_t  pending_reports [$];
	section_t arriving;

	function automatic void clear_run();
		run_count = '0;
		prev_arc = '0;
		prev_phase = '0;
		width_min = '0;
		width_max = '0;
		for (int k = 0; k < 3; k++) begin
			peak[k] = '0;
			trough[k] = '0;
			drop[k] = '0;
			seen[k] = 1'b0;
		end
		valley_max = '0;
		term_floor = '0;
		term_begun = 1'b0;
		term_grew = 1'b0;
		bad_order = 1'b0;
		over_limit = 1'b0;
	endfunction

	// Peak, trough and drawdown of one quantity; the width slot also keeps the deepest
	// valley, taken as the smaller of the fall into it and the climb out of it.
	function automatic void track_trend(input int k, input logic [EXTENT_BITS-1:0] v);
		logic [EXTENT_BITS-1:0] fall;
		logic [EXTENT_BITS-1:0] rise;
		if (!seen[k]) begin
			peak[k] = v;
			trough[k] = v;
			seen[k] = 1'b1;
		end else begin
			if (v < trough[k])
				trough[k] = v;
			if (peak[k] > v && peak[k] - v > drop[k])
				drop[k] = peak[k] - v;
			if (k == TRK_WIDTH) begin
				fall = peak[k] - trough[k];
				rise = v - trough[k];
				if (rise < fall)
					fall = rise;
				if (fall > valley_max)
					valley_max = fall;
			end
			if (v >= peak[k]) begin
				peak[k] = v;
				trough[k] = v;
			end
		end
	endfunction

	function automatic void fold_section(input section_t s);
		logic [EXTENT_BITS:0]   sum;
		logic [EXTENT_BITS-1:0] width;
		logic [31:0]            tol;
		bit                     opening;
		report_t                rpt;
		sum = {1'b0, s.left} + {1'b0, s.right};
		width = sum[EXTENT_BITS] ? '1 : sum[EXTENT_BITS-1:0];
		tol = 32'(geom_eps) * TOL_EPS_WEIGHT + 32'(arc_tol) * TOL_ARC_WEIGHT;
		opening = (run_count == 0);

		if (s.phase > PH_CONTACT || (s.phase == PH_CONTACT && !s.last) ||
				(!opening && (s.arc <= prev_arc || s.phase < prev_phase)))
			bad_order = 1'b1;
		if (run_count != '1)
			run_count = run_count + 1'b1;
		if (run_count > {1'b0, section_limit})
			over_limit = 1'b1;
		prev_arc = s.arc;
		prev_phase = s.phase;

		if (!bad_order && !over_limit) begin
			if (opening) begin
				width_min = width;
				width_max = width;
			end else begin
				if (width < width_min)
					width_min = width;
				if (width > width_max)
					width_max = width;
			end
			if (s.phase == PH_WIDENING || s.phase == PH_JOIN) begin
				track_trend(TRK_LEFT, s.left);
				track_trend(TRK_RIGHT, s.right);
				track_trend(TRK_WIDTH, width);
				term_floor = width;
			end else if (s.phase == PH_TERMINAL || s.phase == PH_CONTACT) begin
				if (!term_begun) begin
					if (!seen[TRK_WIDTH])
						term_floor = width;
					term_begun = 1'b1;
				end
				if ({8'b0, width} > {8'b0, term_floor} + tol)
					term_grew = 1'b1;
				if (width < term_floor)
					term_floor = width;
			end
		end

		if (s.last) begin
			rpt = '0;
			if (over_limit) begin
				rpt.status = ST_UNSUPPORTED;
				rpt.reason = RS_WORK_LIMIT;
			end else if (bad_order) begin
				rpt.status = ST_UNSUPPORTED;
				rpt.reason = RS_INVALID;
			end else begin
				rpt.status = ST_VIOLATION;
				if (32'(valley_max) > tol)
					rpt.reason = RS_WIDTH_VALLEY;
				else if (32'(drop[TRK_LEFT]) > tol || 32'(drop[TRK_RIGHT]) > tol)
					rpt.reason = RS_INWARD_SIDE;
				else if (term_grew)
					rpt.reason = RS_TERMINAL_EXP;
				else begin
					rpt.status = ST_CLEAR;
					rpt.reason = RS_NONE;
				end
				rpt.min_width = width_min;
				rpt.max_width = width_max;
				rpt.left_inward = drop[TRK_LEFT];
				rpt.right_inward = drop[TRK_RIGHT];
				rpt.width_drawdown = drop[TRK_WIDTH];
				rpt.valley = valley_max;
				rpt.count = run_count[COUNT_OUT_BITS-1:0];
			end
			pending_reports = {pending_reports, rpt};
			clear_run();
		end
	endfunction

	function automatic void compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: report field %s expected 0x%0h actual 0x%0h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	function automatic void take_report();
		report_t want;
		if (pending_reports.size() == 0) begin
			$display("%0t: report with no run closed, status %0d reason %0d", $time,
				reports.status, reports.reason);
			mismatches++;
		end else begin
			want = pending_reports.pop_front();
			compare_field("status", 32'(want.status), 32'(reports.status));
			compare_field("reason", 32'(want.reason), 32'(reports.reason));
			compare_field("minimum_width", 32'(want.min_width), 32'(reports.minimum_width));
			compare_field("maximum_width", 32'(want.max_width), 32'(reports.maximum_width));
			compare_field("max_left_inward", 32'(want.left_inward),
				32'(reports.max_left_inward));
			compare_field("max_right_inward", 32'(want.right_inward),
				32'(reports.max_right_inward));
			compare_field("max_width_drawdown", 32'(want.width_drawdown),
				32'(reports.max_width_drawdown));
			compare_field("width_valley_depth", 32'(want.valley),
				32'(reports.width_valley_depth));
			compare_field("sections_evaluated", 32'(want.count),
				32'(reports.sections_evaluated));
		end
	endfunction

	// The report is taken before the section of the same edge, so that a report can
	// never be matched against a run that only closes at that edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			geom_eps = GEOMETRY_EPSILON_RESET;
			arc_tol = ARC_TOLERANCE_RESET;
			section_limit = MAX_SECTIONS_RESET;
			clear_run();
			pending_reports.delete();
			mismatches = 0;
			reports_due = 0;
		end else begin
			if (reports.valid && reports.ready)
				take_report();
			if (sections.valid && sections.ready) begin
				arriving.phase = sections.phase;
				arriving.left = sections.left_extent;
				arriving.right = sections.right_extent;
				arriving.arc = sections.arclength;
				arriving.last = sections.last_section;
				fold_section(arriving);
			end
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[ADDR_BITS-1:2]))
					REG_GEOMETRY_EPSILON: geom_eps = pwdata[REG_BITS-1:0];
					REG_ARC_TOLERANCE: arc_tol = pwdata[REG_BITS-1:0];
					REG_MAX_SECTIONS: section_limit = pwdata[REG_BITS-1:0];
					default: ;
				endcase
			end
			reports_due = pending_reports.size();
		end
	end

endmodule

/* dv/stroke_width_trend_monitor_unit_tb.sv */
module stroke_width_trend_monitor_unit_tb;
	import swtm_pkg::*;

	// The nose phase has no name in the package, and the top phase code is never valid.
	localparam logic [PHASE_BITS-1:0] PH_NOSE = 3'd0;
	localparam logic [PHASE_BITS-1:0] PH_TOP  = 3'd7;

	localparam longint EXTENT_MAX = (longint'(1) << EXTENT_BITS) - 1;
	localparam logic [ARC_BITS-1:0] ARC_START_MAX = 32'hF000_0000;

	// A section transaction may stall for the whole long hold of the report side, so the
	// quiet limit sits well above that hold plus the idle gaps of both sides.
	localparam int unsigned QUIET_LIMIT  = 1500;
	localparam int unsigned LONG_HOLD    = 150;
	localparam int unsigned SETTLE_CYCLES = 4;
	localparam int unsigned DRAIN_CYCLES = 8;

	typedef enum int unsigned {
		FAULT_PHASE_CODE,
		FAULT_EARLY_CONTACT,
		FAULT_ARC_BACK,
		FAULT_PHASE_BACK
	} fault_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                 psel = 1'b0;
	logic                 penable = 1'b0;
	logic                 pwrite = 1'b0;
	logic [ADDR_BITS-1:0] paddr = '0;
	logic [DATA_BITS-1:0] pwdata = '0;
	logic [DATA_BITS-1:0] prdata;
	logic                 pready;

	swtm_section_if section_ch ();
	swtm_report_if  report_ch ();

	int unsigned mismatches;
	int unsigned reports_due;
	int unsigned sections_sent = 0;
	int unsigned reports_taken = 0;
	int unsigned quiet_cycles = 0;

	// Burst flags switch idling off on either side for a stretch of transactions.
	bit section_burst = 1'b0;
	bit report_burst = 1'b0;

	logic [ARC_BITS-1:0] arc_pos;

	stroke_width_trend_monitor_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.section (section_ch),
		.report  (report_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// The checker watches both channels and the register port, predicts every report
	// and hands back the number of failures and of reports still owed.
	swtm_run_checker run_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.sections    (section_ch),
		.reports     (report_ch),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.pready      (pready),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.mismatches  (mismatches),
		.reports_due (reports_due)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// The watchdog ends the run when no transaction of any kind has completed for too
	// long; reset cycles do not count towards it.
	always @(posedge clk) begin
		if (!arst_n || (section_ch.valid && section_ch.ready) ||
				(report_ch.valid && report_ch.ready) || (psel && penable && pready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
			$display("stroke_width_trend_monitor_unit_tb: done, errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Offers one section at a falling edge after a random gap and waits for it to be
	// taken. Valid is left high on return, so back-to-back sections need no gap; every
	// caller that lets time pass without a section lowers it first.
	task automatic send_section(input logic [PHASE_BITS-1:0] ph,
			input logic [EXTENT_BITS-1:0] left, input logic [EXTENT_BITS-1:0] right,
			input logic [ARC_BITS-1:0] arc, input logic last);
		int unsigned gap;
		if ($urandom_range(0, 31) == 0)
			section_burst = !section_burst;
		gap = section_burst ? 0 : $urandom_range(0, 4);
		if (gap != 0) begin
			section_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		section_ch.phase = ph;
		section_ch.left_extent = left;
		section_ch.right_extent = right;
		section_ch.arclength = arc;
		section_ch.last_section = last;
		section_ch.valid = 1'b1;
		@(posedge clk);
		while (!section_ch.ready)
			@(posedge clk);
		@(negedge clk);
		sections_sent++;
	endtask

	// A register write: a setup phase, then an access phase that ends on pready.
	task automatic write_reg(input reg_idx_t idx, input logic [REG_BITS-1:0] value);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = ADDR_BITS'(int'(idx) * 4);
		pwdata = DATA_BITS'(value);
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	// Waits until every owed report has come back, then waits out SETTLE_CYCLES so that the
	// last section is certainly out of the pipeline.
	task automatic settle_idle();
		section_ch.valid = 1'b0;
		while (reports_due != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic configure(input logic [REG_BITS-1:0] eps, input logic [REG_BITS-1:0] arc,
			input logic [REG_BITS-1:0] limit);
		settle_idle();
		write_reg(REG_GEOMETRY_EPSILON, eps);
		write_reg(REG_ARC_TOLERANCE, arc);
		write_reg(REG_MAX_SECTIONS, limit);
	endtask

	// Sends one run. A sound run has rising arclength, phases that never fall and a
	// contact phase only on its last section; extents follow a random walk so that peaks,
	// valleys and drawdowns of all sizes turn up. A spoiled run carries one fault.
	task automatic send_run(input int unsigned length, input bit spoil);
		logic [PHASE_BITS-1:0] ph;
		logic [PHASE_BITS-1:0] sent_ph;
		logic [PHASE_BITS-1:0] prev_ph;
		logic [ARC_BITS-1:0]   prev_arc;
		longint                lv;
		longint                rv;
		int unsigned           bits;
		int unsigned           step;
		int unsigned           arc_step;
		int unsigned           fault_at;
		int unsigned           n;
		fault_t                fault;
		bit                    is_last;
		bits = $urandom_range(4, EXTENT_BITS);
		step = 1 << $urandom_range(0, bits - 1);
		lv = longint'($urandom & ((1 << bits) - 1));
		rv = longint'($urandom & ((1 << bits) - 1));
		arc_step = 1 << $urandom_range(0, 16);
		arc_pos = $urandom_range(0, ARC_START_MAX);
		ph = PHASE_BITS'($urandom_range(0, 2));
		prev_ph = PH_NOSE;
		prev_arc = '0;

		fault = fault_t'($urandom_range(0, 3));
		if (length < 2)
			fault = FAULT_PHASE_CODE;
		if (fault == FAULT_PHASE_CODE)
			fault_at = $urandom_range(0, length - 1);
		else if (fault == FAULT_EARLY_CONTACT)
			fault_at = $urandom_range(0, length - 2);
		else
			fault_at = $urandom_range(1, length - 1);

		for (n = 0; n < length; n++) begin
			is_last = (n == length - 1);
			if (n != 0) begin
				if ($urandom_range(0, 2) == 0 && ph < PH_TERMINAL)
					ph = ph + 1'b1;
				arc_pos = arc_pos + $urandom_range(1, arc_step);
				lv += longint'($urandom_range(0, 2 * step)) - longint'(step);
				rv += longint'($urandom_range(0, 2 * step)) - longint'(step);
			end
			// Now and then a side jumps to one of its extremes.
			if ($urandom_range(0, 15) == 0)
				lv = $urandom_range(0, 1) ? EXTENT_MAX : 0;
			if ($urandom_range(0, 15) == 0)
				rv = $urandom_range(0, 1) ? EXTENT_MAX : 0;
			if (lv < 0)
				lv = 0;
			if (lv > EXTENT_MAX)
				lv = EXTENT_MAX;
			if (rv < 0)
				rv = 0;
			if (rv > EXTENT_MAX)
				rv = EXTENT_MAX;

			sent_ph = (is_last && $urandom_range(0, 2) == 0) ? PH_CONTACT : ph;
			if (spoil && n == fault_at) begin
				case (fault)
					FAULT_PHASE_CODE:
						sent_ph = PHASE_BITS'($urandom_range(int'(PH_CONTACT) + 1, int'(PH_TOP)));
					FAULT_EARLY_CONTACT:
						sent_ph = PH_CONTACT;
					FAULT_ARC_BACK:
						arc_pos = (prev_arc < 4) ? prev_arc : prev_arc - $urandom_range(0, 4);
					FAULT_PHASE_BACK: begin
						// A fall in phase needs an earlier phase above nose; otherwise
						// the arclength is repeated instead.
						if (prev_ph != PH_NOSE)
							sent_ph = PH_NOSE;
						else
							arc_pos = prev_arc;
					end
					default: ;
				endcase
			end
			send_section(sent_ph, lv[EXTENT_BITS-1:0], rv[EXTENT_BITS-1:0], arc_pos, is_last);
			prev_arc = arc_pos;
			prev_ph = sent_ph;
		end
	endtask

	// Random runs until the given number of sections has gone in; about one run in five
	// carries a fault.
	task automatic random_runs(input int unsigned items, input int unsigned longest);
		int unsigned target;
		target = sections_sent + items;
		while (sections_sent < target)
			send_run($urandom_range(1, longest), $urandom_range(0, 4) == 0);
	endtask

	// Report side: a random wait before each transaction, stretches without waits, and
	// twice a long hold during which the section side keeps offering, so the report
	// register fills and the input stalls behind a last section.
	initial begin : report_sink
		int unsigned gap;
		report_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if ($urandom_range(0, 31) == 0)
				report_burst = !report_burst;
			gap = report_burst ? 0 : $urandom_range(0, 4);
			if (reports_taken == 30 || reports_taken == 160) begin
				report_ch.ready = 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
			end else if (gap != 0) begin
				report_ch.ready = 1'b0;
				repeat (gap) @(negedge clk);
			end
			report_ch.ready = 1'b1;
			@(posedge clk);
			while (!report_ch.valid)
				@(posedge clk);
			reports_taken++;
			@(negedge clk);
		end
	end

	initial begin : stimulus
		section_ch.valid = 1'b0;
		section_ch.phase = PH_NOSE;
		section_ch.left_extent = '0;
		section_ch.right_extent = '0;
		section_ch.arclength = '0;
		section_ch.last_section = 1'b0;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed runs under the reset settings, where the tolerance is 160.
		// A lone nose section at zero, then a lone terminal section at full extent,
		// whose width saturates.
		send_section(PH_NOSE, '0, '0, '0, 1'b1);
		send_section(PH_TERMINAL, '1, '1, '1, 1'b1);
		// A width valley of 500 during widening.
		send_section(PH_WIDENING, 24'd500, 24'd500, 32'd10, 1'b0);
		send_section(PH_WIDENING, 24'd250, 24'd250, 32'd20, 1'b0);
		send_section(PH_WIDENING, 24'd500, 24'd500, 32'd30, 1'b0);
		send_section(PH_JOIN, 24'd500, 24'd500, 32'd40, 1'b1);
		// The left side pulls in by 300 while the width holds.
		send_section(PH_WIDENING, 24'd1000, 24'd1000, 32'd10, 1'b0);
		send_section(PH_WIDENING, 24'd700, 24'd1300, 32'd20, 1'b0);
		send_section(PH_JOIN, 24'd700, 24'd1300, 32'd30, 1'b1);
		// The terminal width grows back above its floor by more than the tolerance.
		send_section(PH_TERMINAL, 24'd500, 24'd500, 32'd10, 1'b0);
		send_section(PH_TERMINAL, 24'd250, 24'd250, 32'd20, 1'b0);
		send_section(PH_CONTACT, 24'd400, 24'd400, 32'd30, 1'b1);
		// Invalid sections: an undefined phase code, contact before the end, an
		// arclength that does not rise, and a phase that falls back.
		send_section(PH_TOP, 24'd1, 24'd1, 32'd5, 1'b1);
		send_section(PH_CONTACT, 24'd1, 24'd1, 32'd5, 1'b0);
		send_section(PH_CONTACT, 24'd1, 24'd1, 32'd6, 1'b1);
		send_section(PH_NOSE, 24'd1, 24'd1, 32'd100, 1'b0);
		send_section(PH_NOSE, 24'd1, 24'd1, 32'd100, 1'b1);
		send_section(PH_JOIN, 24'd1, 24'd1, 32'd1, 1'b0);
		send_section(PH_WIDENING, 24'd1, 24'd1, 32'd2, 1'b1);

		// Epsilon and arc tolerance of one (a tolerance of 34) and the largest section limit.
		configure(16'd1, 16'd1, 16'hFFFF);
		random_runs(350, 12);

		// The largest tolerance.
		configure(16'hFFFF, 16'hFFFF, 16'hFFFF);
		random_runs(250, 12);

		// A limit of four sections: first a run of five that is also out of order,
		// where the work limit must win, then short random runs around the limit.
		configure(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)), 16'd4);
		send_section(PH_NOSE, 24'd10, 24'd10, 32'd9, 1'b0);
		send_section(PH_NOSE, 24'd10, 24'd10, 32'd8, 1'b0);
		send_section(PH_WIDENING, 24'd10, 24'd10, 32'd10, 1'b0);
		send_section(PH_JOIN, 24'd10, 24'd10, 32'd11, 1'b0);
		send_section(PH_TERMINAL, 24'd10, 24'd10, 32'd12, 1'b1);
		random_runs(300, 7);

		// A limit of one section: every run longer than one section hits it.
		configure(16'd1, 16'hFFFF, 16'd1);
		random_runs(150, 3);

		// Random settings with a section limit of at least 200.
		configure(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
			16'($urandom_range(200, 65535)));
		random_runs(500, 12);

		section_ch.valid = 1'b0;
		while (reports_due != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0)
			$display("stroke_width_trend_monitor_unit_tb: done, clean");
		else
			$display("stroke_width_trend_monitor_unit_tb: done, errors");
		$finish;
	end

endmodule

/* stroke_width_trend_monitor_unit.f */
hw/rtl/swtm_pkg.sv
hw/rtl/swtm_if.sv
hw/rtl/swtm_cfg_regs.sv
hw/rtl/swtm_tracker.sv
hw/rtl/stroke_width_trend_monitor_unit.sv
dv/swtm_run_checker.sv
dv/stroke_width_trend_monitor_unit_tb.sv
